// ----- hdl/sfb_pkg.sv -----
// Package for the serial frame builder: frame constants, item types,
// sequencer states, and the CRC and header byte functions.
// Depends on nothing; every other file imports it.
package sfb_pkg;

  localparam int MAX_FRAME_BYTES = 48;
  localparam int OVERHEAD        = 13;
  localparam int REM_W           = $clog2(MAX_FRAME_BYTES - OVERHEAD + 1);
  localparam int HDR_BYTES       = 11;
  localparam int STEP_W          = $clog2(HDR_BYTES);
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0]  HDR_SYNC   = 8'h55;
  localparam logic [7:0]  HDR_FLAG   = 8'h40;
  localparam logic [7:0]  HDR_CLASS  = 8'h0D;
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] SEED_RESET = 16'h3692;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_DATA,
    CMD_TOO_LONG,
    CMD_NO_FRAME
  } cmd_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_NO_FRAME = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_CRC_LO,
    ST_CRC_HI
  } back_state_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        close;
    logic [15:0] sequence_req;
    logic [31:0] address;
    logic [7:0]  command;
    logic [7:0]  total;
    logic [7:0]  data_byte;
  } cmd_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [STEP_W-1:0] step, input cmd_t c);
    logic [7:0] b;
    unique case (step)
      STEP_W'(0):  b = HDR_SYNC;
      STEP_W'(1):  b = c.total;
      STEP_W'(2):  b = c.address[7:0];
      STEP_W'(3):  b = c.address[15:8];
      STEP_W'(4):  b = c.address[23:16];
      STEP_W'(5):  b = c.address[31:24];
      STEP_W'(6):  b = c.sequence_req[7:0];
      STEP_W'(7):  b = c.sequence_req[15:8];
      STEP_W'(8):  b = HDR_FLAG;
      STEP_W'(9):  b = HDR_CLASS;
      STEP_W'(10): b = c.command;
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/serial_frame_builder_crc16.sv -----
// Serial frame builder with reflected CRC-16: top level joining front end,
// command queue and back-end byte sequencer. Depends on sfb_pkg.
// Items are registered in the command queue, then the result register. The back end
// emits one byte per cycle while the result is free or popped; a start gives 11 header
// bytes, a payload item or an error one byte; a closing item then adds the CRC pair.
// Reset (rst, synchronous): closes any frame, empties queue and result, seed 0x3692.
module serial_frame_builder_crc16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [15:0] sequence_req,
  input  logic [31:0] address,
  input  logic [7:0]  command,
  input  logic [7:0]  body_len,
  input  logic [7:0]  data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_byte,
  output logic        last,
  output logic [1:0]  status
);
  import sfb_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wr, q_rd;

  sfb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .func           (func),
    .sequence_req   (sequence_req),
    .address        (address),
    .command        (command),
    .body_len       (body_len),
    .data_byte      (data_byte),
    .q_push         (q_push),
    .q_data         (q_wr),
    .q_full         (q_full)
  );

  sfb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  sfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .head       (q_rd),
    .head_valid (!q_empty),
    .head_pop   (q_pop),
    .empty      (empty),
    .pop        (pop),
    .frame_byte (frame_byte),
    .last       (last),
    .status     (status)
  );

endmodule

// ----- hdl/sfb_front.sv -----
// Front end: accepts input items, tracks the open frame and classifies
// each item into a command for the back end. Depends on sfb_pkg.
module sfb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              func,
  input  logic [15:0]       sequence_req,
  input  logic [31:0]       address,
  input  logic [7:0]        command,
  input  logic [7:0]        body_len,
  input  logic [7:0]        data_byte,
  output logic              q_push,
  output sfb_pkg::cmd_t     q_data,
  input  logic              q_full
);
  import sfb_pkg::*;

  logic             frame_open, frame_open_next;
  logic [REM_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [8:0]       total_sum;
  logic             too_long;

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    total_sum            = 9'(OVERHEAD) + {1'b0, body_len};
    too_long             = total_sum > 9'(MAX_FRAME_BYTES);
    frame_open_next      = frame_open;
    bytes_remaining_next = bytes_remaining;
    q_data.kind          = CMD_NO_FRAME;
    q_data.close         = 1'b0;
    q_data.sequence_req  = sequence_req;
    q_data.address       = address;
    q_data.command       = command;
    q_data.total         = total_sum[7:0];
    q_data.data_byte     = data_byte;
    if (func == FUNC_START) begin
      if (too_long) begin
        q_data.kind          = CMD_TOO_LONG;
        frame_open_next      = 1'b0;
        bytes_remaining_next = '0;
      end else begin
        q_data.kind          = CMD_START;
        q_data.close         = body_len == 8'd0;
        frame_open_next      = body_len != 8'd0;
        bytes_remaining_next = REM_W'(body_len);
      end
    end else if (frame_open && bytes_remaining != '0) begin
      q_data.kind          = CMD_DATA;
      q_data.close         = bytes_remaining == REM_W'(1);
      bytes_remaining_next = bytes_remaining - REM_W'(1);
      frame_open_next      = bytes_remaining != REM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      bytes_remaining <= '0;
    end else if (q_push) begin
      frame_open      <= frame_open_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> bytes_remaining != '0)
    else $error("open frame with no payload bytes due");

endmodule

// ----- hdl/sfb_queue.sv -----
// Short command queue between front and back ends.
// Depends on sfb_pkg for the command type and depth.
module sfb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfb_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          pop,
  output sfb_pkg::cmd_t rd_data,
  output logic          empty
);
  import sfb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- hdl/sfb_back.sv -----
// Back end: byte sequencer that turns commands into frame bytes, keeps the
// running CRC and the seed register, and drives the result register.
// Depends on sfb_pkg.
module sfb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data,
  input  sfb_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          head_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    frame_byte,
  output logic          last,
  output logic [1:0]    status
);
  import sfb_pkg::*;

  back_state_t       st, st_next;
  logic [STEP_W-1:0] step, step_next;
  logic [15:0]       crc, crc_next;
  logic [15:0]       crc_seed;
  logic              out_valid;
  logic [7:0]        out_byte;
  logic              out_last;
  status_t           out_status;
  logic              adv;
  logic              emit;
  logic [7:0]        emit_byte;
  logic              emit_last;
  status_t           emit_status;
  logic [7:0]        hb;

  assign cfg_ready  = 1'b1;
  assign empty      = !out_valid;
  assign frame_byte = out_byte;
  assign last       = out_last;
  assign status     = out_status;
  assign adv        = !out_valid || pop;

  always_comb begin
    st_next     = st;
    step_next   = step;
    crc_next    = crc;
    head_pop    = 1'b0;
    emit        = 1'b0;
    emit_byte   = 8'h00;
    emit_last   = 1'b0;
    emit_status = STATUS_OK;
    hb          = hdr_byte(step, head);
    unique case (st)
      ST_IDLE: begin
        if (head_valid && adv) begin
          emit = 1'b1;
          unique case (head.kind)
            CMD_START: begin
              emit_byte = HDR_SYNC;
              crc_next  = crc_feed(crc_seed, HDR_SYNC);
              step_next = STEP_W'(1);
              st_next   = ST_HDR;
            end
            CMD_DATA: begin
              emit_byte = head.data_byte;
              crc_next  = crc_feed(crc, head.data_byte);
              head_pop  = 1'b1;
              if (head.close) begin
                st_next = ST_CRC_LO;
              end
            end
            CMD_TOO_LONG: begin
              emit_last   = 1'b1;
              emit_status = STATUS_TOO_LONG;
              head_pop    = 1'b1;
            end
            CMD_NO_FRAME: begin
              emit_last   = 1'b1;
              emit_status = STATUS_NO_FRAME;
              head_pop    = 1'b1;
            end
          endcase
        end
      end
      ST_HDR: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = hb;
          crc_next  = crc_feed(crc, hb);
          step_next = step + STEP_W'(1);
          if (step == STEP_W'(HDR_BYTES - 1)) begin
            head_pop = 1'b1;
            st_next  = head.close ? ST_CRC_LO : ST_IDLE;
          end
        end
      end
      ST_CRC_LO: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = crc[7:0];
          st_next   = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        if (adv) begin
          emit      = 1'b1;
          emit_byte = crc[15:8];
          emit_last = 1'b1;
          st_next   = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      step      <= '0;
      crc       <= '0;
      out_valid <= 1'b0;
    end else begin
      st   <= st_next;
      step <= step_next;
      crc  <= crc_next;
      if (adv) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed <= SEED_RESET;
    end else if (cfg_valid) begin
      crc_seed <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_byte   <= emit_byte;
      out_last   <= emit_last;
      out_status <= emit_status;
    end
  end

  a_hdr_head: assert property (@(posedge clk) disable iff (rst)
    st == ST_HDR |-> head_valid && head.kind == CMD_START)
    else $error("header steps without a start at the queue head");

  a_crc_last: assert property (@(posedge clk) disable iff (rst)
    st == ST_CRC_HI && adv |=> out_valid && out_last && out_status == STATUS_OK)
    else $error("CRC high byte not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != STATUS_OK |-> out_byte == 8'h00 && out_last)
    else $error("error item with data or without last");

endmodule
